// ===== hdl/qla_pkg.sv =====
// Shared constants, register codes and control types for the tabular Q-learning agent.
// No dependencies; qla_cfg, qla_update and the top level in hdl/ import this package.
`default_nettype none

package qla_pkg;

  // Fixed field widths of the item and result channels.
  localparam int STATE_W  = 8;
  localparam int ACT_W    = 2;
  localparam int REWARD_W = 17;
  localparam int PROB_W   = 7;
  localparam int RATE_W   = 16;

  // Four actions per state, action values carry 12 fraction bits.
  localparam int NUM_ACT = 4;
  localparam int Q_FRAC  = 12;

  // Defaults for the top-level parameters.
  localparam int NUM_STATES_DEF = 256;
  localparam int Q_WIDTH_DEF    = 32;

  // Register file: two 32-bit registers at byte addresses 0 and 4.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_LEARN_RATE = 1'b0;
  localparam logic REG_DISCOUNT   = 1'b1;

  localparam logic [RATE_W-1:0] LEARN_RATE_RST = 16'd45875;
  localparam logic [RATE_W-1:0] DISCOUNT_RST   = 16'd62259;

  // Load enables for the registers of the update datapath.
  typedef struct packed {
    logic gamma;
    logic target;
    logic diff;
    logic step;
    logic sat;
  } upd_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/qla_qmem.sv =====
// Action-value memory: one row of four values per state, one write and two read ports.
// Depends on nothing but its parameters; instantiated by the top level.
`default_nettype none

module qla_qmem #(
  parameter int ROWS = 256,
  parameter int AW   = 8,
  parameter int DW   = 128
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_a,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds between reads, so the sequencer can use it for several cycles.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qla_cfg.sv =====
// APB-style register file holding the learning rate and the discount factor.
// Depends on qla_pkg for widths, register codes and reset values.
`default_nettype none

module qla_cfg
  import qla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output logic      [RATE_W-1:0] learn_rate,
  output logic      [RATE_W-1:0] discount
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= LEARN_RATE_RST;
      discount   <= DISCOUNT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_LEARN_RATE: learn_rate <= pwdata[RATE_W-1:0];
        REG_DISCOUNT:   discount   <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LEARN_RATE: prdata = CFG_DW'(learn_rate);
      REG_DISCOUNT:   prdata = CFG_DW'(discount);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/qla_update.sv =====
// Fixed-point update datapath: gamma term, target, difference, learning step, saturation.
// Depends on qla_pkg for field widths and the control struct; the top level sequences it.
`default_nettype none

module qla_update
  import qla_pkg::*;
#(
  parameter int Q_WIDTH = Q_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire upd_ctl_t                   ctl,
  input  wire logic        [RATE_W-1:0]   learn_rate,
  input  wire logic        [RATE_W-1:0]   discount,
  input  wire logic signed [REWARD_W-1:0] reward,
  input  wire logic signed [Q_WIDTH-1:0]  max_q,
  input  wire logic signed [Q_WIDTH-1:0]  cur_q,
  output logic signed      [Q_WIDTH-1:0]  upd_q
);

  // Widest of the stored value and the scaled reward, then one growth bit per add.
  localparam int RW   = REWARD_W + Q_FRAC;
  localparam int MW   = (Q_WIDTH > RW) ? Q_WIDTH : RW;
  localparam int TW   = MW + 1;
  localparam int DW   = MW + 2;
  localparam int SUMW = DW + 1;
  localparam int PW_G = Q_WIDTH + RATE_W + 1;
  localparam int PW_S = DW + RATE_W + 1;

  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'({1'b0, {(Q_WIDTH-1){1'b1}}});
  localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

  logic signed [PW_G-1:0] gprod;
  logic signed [TW-1:0]   target;
  logic signed [DW-1:0]   diff;
  logic signed [PW_S-1:0] sprod;

  logic signed [TW-1:0]   target_next;
  logic signed [SUMW-1:0] sum;

  // The products are floored by an arithmetic right shift of 16.
  assign target_next = (TW'(reward) <<< Q_FRAC)
                     + TW'($signed(gprod[PW_G-1:RATE_W]));
  assign sum = SUMW'($signed(sprod[PW_S-1:RATE_W])) + SUMW'(cur_q);

  always_ff @(posedge clk) begin
    if (ctl.gamma) begin
      gprod <= PW_G'(max_q) * PW_G'($signed({1'b0, discount}));
    end
    if (ctl.target) begin
      target <= target_next;
    end
    if (ctl.diff) begin
      diff <= DW'(target) - DW'(cur_q);
    end
    if (ctl.step) begin
      sprod <= PW_S'(diff) * PW_S'($signed({1'b0, learn_rate}));
    end
    if (ctl.sat) begin
      if (sum > SAT_HI) begin
        upd_q <= Q_WIDTH'(SAT_HI);
      end else if (sum < SAT_LO) begin
        upd_q <= Q_WIDTH'(SAT_LO);
      end else begin
        upd_q <= Q_WIDTH'(sum);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tabular_q_learning_agent_top.sv =====
// Tabular Q-learning agent with epsilon-greedy action choice: top level and sequencer.
// Depends on qla_pkg, qla_cfg, qla_qmem and qla_update.
`default_nettype none

// The agent keeps four signed action values per state (12 fraction bits) in one
// on-chip memory, one row per state. A start item (kind 0) only picks an action for
// next_state; a transition item (kind 1) first applies the Q-learning update to the
// entry of prev_state and prev_action, then picks from the updated table. The pick is
// greedy (lowest action among equal maxima) when random_draw is above
// epsilon_hundredths, otherwise it is random_action and explored is set. Items are
// worked one at a time by a sequencer around the memory: a start item reads the two rows
// and picks; a transition item also runs the chain of two multiplies, two adds and a
// saturating add that must finish before the row is written back, then picks. The
// result sits in an output register, so the next item is accepted while a result still
// waits to be taken. After reset the memory is cleared one row per cycle while
// item_stall stays high; register writes are taken during that pass. State numbers at
// or above NUM_STATES wrap modulo NUM_STATES. learn_rate lies at byte address 0 and
// discount at address 4, both unsigned Q0.16 in the low 16 bits.

module tabular_q_learning_agent_top
  import qla_pkg::*;
#(
  parameter int NUM_STATES = NUM_STATES_DEF,
  parameter int Q_WIDTH    = Q_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Item channel.
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire logic                       kind,
  input  wire logic        [STATE_W-1:0]  prev_state,
  input  wire logic        [ACT_W-1:0]    prev_action,
  input  wire logic signed [REWARD_W-1:0] reward,
  input  wire logic        [STATE_W-1:0]  next_state,
  input  wire logic        [PROB_W-1:0]   epsilon_hundredths,
  input  wire logic        [PROB_W-1:0]   random_draw,
  input  wire logic        [ACT_W-1:0]    random_action,
  // Result channel.
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic             [ACT_W-1:0]    chosen_action,
  output logic                            explored,
  // Register port.
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic        [CFG_AW-1:0]   paddr,
  input  wire logic        [CFG_DW-1:0]   pwdata,
  output logic             [CFG_DW-1:0]   prdata,
  output logic                            pready
);

  localparam int SW    = $clog2(NUM_STATES);
  localparam int ROWW  = NUM_ACT * Q_WIDTH;
  // Reciprocal for the state wrap; exact after one correction for 8-bit states.
  localparam int RECIP = 65536 / NUM_STATES;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_INDEX  = 11'b000_0000_0100,
    ST_LOAD   = 11'b000_0000_1000,
    ST_GAMMA  = 11'b000_0001_0000,
    ST_TARGET = 11'b000_0010_0000,
    ST_DIFF   = 11'b000_0100_0000,
    ST_STEP   = 11'b000_1000_0000,
    ST_SAT    = 11'b001_0000_0000,
    ST_WRITE  = 11'b010_0000_0000,
    ST_CHOOSE = 11'b100_0000_0000
  } seq_state_t;

  // Wraps an 8-bit state number into the table: multiply by the reciprocal,
  // subtract the quotient times NUM_STATES and correct once.
  function automatic logic [SW-1:0] wrap_state(input logic [STATE_W-1:0] s);
    logic [23:0] prod;
    logic [15:0] qn;
    logic [8:0]  r;
    prod = 24'(s) * 24'(RECIP);
    qn   = 16'(prod[23:16]) * 16'(NUM_STATES);
    r    = 9'(s) - 9'(qn);
    if (NUM_STATES > 255) begin
      return SW'(s);
    end
    if (32'(r) >= NUM_STATES) begin
      r = r - 9'(NUM_STATES);
    end
    return SW'(r);
  endfunction

  // Greedy pick over one row: strictly greater replaces, so ties keep the lowest action.
  function automatic logic [ACT_W-1:0] best_action(input logic [ROWW-1:0] row);
    logic signed [Q_WIDTH-1:0] m;
    logic signed [Q_WIDTH-1:0] v;
    logic [ACT_W-1:0]          pick;
    m    = row[Q_WIDTH-1:0];
    pick = '0;
    for (int a = 1; a < NUM_ACT; a++) begin
      v = row[a*Q_WIDTH +: Q_WIDTH];
      if (v > m) begin
        m    = v;
        pick = ACT_W'(a);
      end
    end
    return pick;
  endfunction

  seq_state_t state;
  seq_state_t state_next;

  // Fields of the item at work.
  logic                       kind_r;
  logic        [STATE_W-1:0]  prev_state_r;
  logic        [ACT_W-1:0]    prev_action_r;
  logic signed [REWARD_W-1:0] reward_r;
  logic        [STATE_W-1:0]  next_state_r;
  logic        [PROB_W-1:0]   epsilon_r;
  logic        [PROB_W-1:0]   draw_r;
  logic        [ACT_W-1:0]    random_action_r;

  logic [SW-1:0]   ns_idx;
  logic [SW-1:0]   ps_idx;
  logic [SW-1:0]   clr_cnt;
  logic [ROWW-1:0] next_row;

  logic signed [Q_WIDTH-1:0] max_q;
  logic signed [Q_WIDTH-1:0] cur_q;
  logic signed [Q_WIDTH-1:0] upd_q;

  logic [RATE_W-1:0] learn_rate;
  logic [RATE_W-1:0] discount;

  logic            mem_we;
  logic [SW-1:0]   mem_waddr;
  logic [ROWW-1:0] mem_wdata;
  logic            mem_re;
  logic [SW-1:0]   ns_wrap;
  logic [SW-1:0]   ps_wrap;
  logic [ROWW-1:0] rd_next;
  logic [ROWW-1:0] rd_prev;
  logic [ROWW-1:0] write_row;

  upd_ctl_t   upd_ctl;
  logic       item_take;
  logic       out_load;
  logic [ACT_W-1:0] greedy_next;

  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign out_load   = (state == ST_CHOOSE) && (!result_valid || !result_stall);

  assign ns_wrap = wrap_state(next_state_r);
  assign ps_wrap = wrap_state(prev_state_r);

  // The updated row of prev_state: the read row with one entry replaced.
  always_comb begin
    write_row = rd_prev;
    write_row[prev_action_r*Q_WIDTH +: Q_WIDTH] = upd_q;
  end

  assign greedy_next = best_action(rd_next);

  // Memory port use: clearing pass, one read of both rows, one write-back.
  always_comb begin
    mem_re    = (state == ST_INDEX);
    mem_we    = (state == ST_CLEAR) || (state == ST_WRITE);
    mem_waddr = (state == ST_CLEAR) ? clr_cnt : ps_idx;
    mem_wdata = (state == ST_CLEAR) ? '0 : write_row;
  end

  always_comb begin
    upd_ctl.gamma  = (state == ST_GAMMA);
    upd_ctl.target = (state == ST_TARGET);
    upd_ctl.diff   = (state == ST_DIFF);
    upd_ctl.step   = (state == ST_STEP);
    upd_ctl.sat    = (state == ST_SAT);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == SW'(NUM_STATES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_take) begin
          state_next = ST_INDEX;
        end
      end
      ST_INDEX:  state_next = ST_LOAD;
      ST_LOAD:   state_next = kind_r ? ST_GAMMA : ST_CHOOSE;
      ST_GAMMA:  state_next = ST_TARGET;
      ST_TARGET: state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_STEP;
      ST_STEP:   state_next = ST_SAT;
      ST_SAT:    state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_CHOOSE;
      ST_CHOOSE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SW'(1);
      end
    end
  end

  // Item capture and per-item working registers.
  always_ff @(posedge clk) begin
    if (item_take) begin
      kind_r          <= kind;
      prev_state_r    <= prev_state;
      prev_action_r   <= prev_action;
      reward_r        <= reward;
      next_state_r    <= next_state;
      epsilon_r       <= epsilon_hundredths;
      draw_r          <= random_draw;
      random_action_r <= random_action;
    end
    if (state == ST_INDEX) begin
      ns_idx <= ns_wrap;
      ps_idx <= ps_wrap;
    end
    if (state == ST_LOAD) begin
      next_row <= rd_next;
      max_q    <= rd_next[greedy_next*Q_WIDTH +: Q_WIDTH];
      cur_q    <= rd_prev[prev_action_r*Q_WIDTH +: Q_WIDTH];
    end
    // When the updated entry lies in the row of next_state, the choice sees the new value.
    if ((state == ST_WRITE) && (ps_idx == ns_idx)) begin
      next_row <= write_row;
    end
  end

  // Output register: the finished result waits here while the next item starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (draw_r > epsilon_r) begin
        chosen_action <= best_action(next_row);
        explored      <= 1'b0;
      end else begin
        chosen_action <= random_action_r;
        explored      <= 1'b1;
      end
    end
  end

  qla_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .learn_rate (learn_rate),
    .discount   (discount)
  );

  qla_qmem #(
    .ROWS (NUM_STATES),
    .AW   (SW),
    .DW   (ROWW)
  ) u_qmem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (ns_wrap),
    .raddr_b (ps_wrap),
    .rdata_a (rd_next),
    .rdata_b (rd_prev)
  );

  qla_update #(
    .Q_WIDTH (Q_WIDTH)
  ) u_update (
    .clk        (clk),
    .ctl        (upd_ctl),
    .learn_rate (learn_rate),
    .discount   (discount),
    .reward     (reward_r),
    .max_q      (max_q),
    .cur_q      (cur_q),
    .upd_q      (upd_q)
  );

`ifndef SYNTHESIS
  // A new result appears only at the end of the choice step.
  a_result_from_choose: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_CHOOSE)
    else $error("result appeared outside the choice step");

  // An accepted item always starts with the row read.
  a_take_starts_read: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> state == ST_INDEX)
    else $error("accepted item did not start the row read");

  // No item is taken as reset is released, while the table is cleared.
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> item_stall)
    else $error("item channel open before the clearing pass");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the tabular Q-learning agent: a directed table, then
// agent episodes, saturation runs and noise, with register changes between phases.
// Depends on qla_pkg and the RTL under hdl/ only.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qla_pkg::*;

  // Block configuration under test; the predictor uses the same numbers.
  localparam int NUM_STATES = NUM_STATES_DEF;
  localparam int Q_WIDTH    = Q_WIDTH_DEF;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 3;
  // Drain margin after the last result; each write-back finishes before its result
  // appears, so this only adds slack before the rates change.
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 265;
  localparam int NUM_PHASES   = 6;
  // Watchdog limit, set well above the slowest legal run.
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  localparam longint Q_MAX = (64'sd1 <<< (Q_WIDTH - 1)) - 1;
  localparam longint Q_MIN = -Q_MAX - 1;

  // Item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_UP    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DOWN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LEFT  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RIGHT = 2'd3;

  // One input item, field for field as on the item channel.
  typedef struct packed {
    logic                       kind;
    logic        [STATE_W-1:0]  prev_state;
    logic        [ACT_W-1:0]    prev_action;
    logic signed [REWARD_W-1:0] reward;
    logic        [STATE_W-1:0]  next_state;
    logic        [PROB_W-1:0]   epsilon;
    logic        [PROB_W-1:0]   draw;
    logic        [ACT_W-1:0]    random_action;
  } agent_item_t;

  // One result: the action picked for next_state and whether it was explored.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             explored;
  } pick_t;

  // A directed row carries a hand-written expectation only when typed_in is set.
  typedef struct packed {
    agent_item_t item;
    logic        typed_in;
    pick_t       want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       item_valid    = 1'b0;
  logic                       item_stall;
  logic                       kind          = KIND_START;
  logic        [STATE_W-1:0]  prev_state    = '0;
  logic        [ACT_W-1:0]    prev_action   = '0;
  logic signed [REWARD_W-1:0] reward        = '0;
  logic        [STATE_W-1:0]  next_state    = '0;
  logic        [PROB_W-1:0]   epsilon_hundredths = '0;
  logic        [PROB_W-1:0]   random_draw   = '0;
  logic        [ACT_W-1:0]    random_action = '0;

  logic                       result_valid;
  logic                       result_stall  = 1'b0;
  logic        [ACT_W-1:0]    chosen_action;
  logic                       explored;

  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic        [CFG_AW-1:0]   paddr   = '0;
  logic        [CFG_DW-1:0]   pwdata  = '0;
  logic        [CFG_DW-1:0]   prdata;
  logic                       pready;

  // Predictor state: the action-value table and the two rates, as the block holds them.
  longint           q_table [NUM_STATES*NUM_ACT];
  logic [RATE_W-1:0] lr_q16    = LEARN_RATE_RST;
  logic [RATE_W-1:0] gamma_q16 = DISCOUNT_RST;

  // Picks predicted for accepted items, oldest first.
  pick_t pending_picks [$];

  int mismatches     = 0;
  int items_sent     = 0;
  int step_items     = 0;
  int explore_picks  = 0;
  int sat_updates    = 0;
  int results_seen   = 0;
  int settings_done  = 0;
  int holds_asked    = 0;
  int holds_done     = 0;
  int burst_left     = 0;

  // Directed table. Rows with a typed expectation can be checked by eye: a cleared
  // table picks action 0, and an explore pick is simply random_action.
  dir_row_t directed_rows [0:22] = '{
    // Cleared table, greedy: tie across all four picks the lowest action.
    '{'{KIND_START, 0, ACT_UP, 0, 0, 0, 99, ACT_RIGHT}, 1'b1, '{ACT_UP, 1'b0}},
    // Full epsilon explores.
    '{'{KIND_START, 0, ACT_UP, 0, 255, 100, 0, ACT_LEFT}, 1'b1, '{ACT_LEFT, 1'b1}},
    // Raw 7-bit epsilon and draw beyond 100, equal, so still explore.
    '{'{KIND_START, 0, ACT_UP, 0, 128, 127, 127, ACT_DOWN}, 1'b1, '{ACT_DOWN, 1'b1}},
    // Draw equal to epsilon at zero explores.
    '{'{KIND_START, 0, ACT_UP, 0, 1, 0, 0, ACT_UP}, 1'b1, '{ACT_UP, 1'b1}},
    // Start item with extreme junk in the unused fields leaves the table alone.
    '{'{KIND_START, 255, ACT_RIGHT, -65536, 7, 0, 127, ACT_RIGHT}, 1'b1, '{ACT_UP, 1'b0}},
    // Largest reward into one entry makes it the greedy pick.
    '{'{KIND_STEP, 5, ACT_LEFT, 65535, 5, 0, 99, ACT_UP}, 1'b1, '{ACT_LEFT, 1'b0}},
    // Repeat until the entry runs into the top of the Q range.
    '{'{KIND_STEP, 5, ACT_LEFT, 65535, 5, 0, 99, ACT_UP}, 1'b0, '0},
    '{'{KIND_STEP, 5, ACT_LEFT, 65535, 5, 0, 99, ACT_UP}, 1'b0, '0},
    '{'{KIND_STEP, 5, ACT_LEFT, 65535, 5, 0, 99, ACT_UP}, 1'b0, '0},
    '{'{KIND_STEP, 5, ACT_LEFT, 65535, 5, 0, 99, ACT_UP}, 1'b0, '0},
    '{'{KIND_STEP, 5, ACT_LEFT, 65535, 5, 0, 99, ACT_UP}, 1'b0, '0},
    '{'{KIND_STEP, 5, ACT_LEFT, 65535, 5, 0, 99, ACT_UP}, 1'b0, '0},
    '{'{KIND_STEP, 5, ACT_LEFT, 65535, 5, 0, 99, ACT_UP}, 1'b0, '0},
    '{'{KIND_STEP, 5, ACT_LEFT, 65535, 5, 0, 99, ACT_UP}, 1'b0, '0},
    // A second saturated entry ties with the first; the lower action must win.
    '{'{KIND_STEP, 5, ACT_DOWN, 65535, 5, 0, 99, ACT_UP}, 1'b0, '0},
    // A reward of -65535 pushes action 0 below the zero entries.
    '{'{KIND_STEP, 9, ACT_UP, -65535, 9, 0, 99, ACT_UP}, 1'b1, '{ACT_DOWN, 1'b0}},
    // Drive every entry of the state negative: the true maximum must be used.
    '{'{KIND_STEP, 9, ACT_DOWN, -65535, 9, 0, 99, ACT_UP}, 1'b0, '0},
    '{'{KIND_STEP, 9, ACT_LEFT, -65535, 9, 0, 99, ACT_UP}, 1'b0, '0},
    '{'{KIND_STEP, 9, ACT_RIGHT, -65535, 9, 0, 99, ACT_UP}, 1'b0, '0},
    '{'{KIND_START, 0, ACT_UP, 0, 9, 0, 99, ACT_RIGHT}, 1'b0, '0},
    // A transition that explores still returns random_action.
    '{'{KIND_STEP, 0, ACT_UP, 0, 255, 100, 99, ACT_RIGHT}, 1'b1, '{ACT_RIGHT, 1'b1}},
    '{'{KIND_STEP, 255, ACT_RIGHT, -1, 0, 50, 51, ACT_UP}, 1'b0, '0},
    // Draw just above epsilon: greedy.
    '{'{KIND_STEP, 200, ACT_DOWN, 1, 200, 99, 100, ACT_LEFT}, 1'b0, '0}
  };

  tabular_q_learning_agent_top #(
    .NUM_STATES(NUM_STATES),
    .Q_WIDTH   (Q_WIDTH)
  ) dut (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .kind              (kind),
    .prev_state        (prev_state),
    .prev_action       (prev_action),
    .reward            (reward),
    .next_state        (next_state),
    .epsilon_hundredths(epsilon_hundredths),
    .random_draw       (random_draw),
    .random_action     (random_action),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .chosen_action     (chosen_action),
    .explored          (explored),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #CLK_HALF clk = ~clk;

  // floor(x * k / 2^16): arithmetic shift of the exact product rounds toward minus infinity.
  function automatic longint scale_q16(input longint x, input logic [RATE_W-1:0] k);
    return (x * longint'({48'd0, k})) >>> 16;
  endfunction

  // Highest entry of a state, lowest action on ties.
  function automatic logic [ACT_W-1:0] greedy_action(input int unsigned s, output longint best);
    logic [ACT_W-1:0] pick;
    longint v;
    pick = ACT_UP;
    best = q_table[s*NUM_ACT];
    for (int a = 1; a < NUM_ACT; a++) begin
      v = q_table[s*NUM_ACT + a];
      if (v > best) begin
        best = v;
        pick = ACT_W'(a);
      end
    end
    return pick;
  endfunction

  // Applies one accepted item to the predicted table and returns the pick it yields.
  function automatic pick_t predict_pick(input agent_item_t it);
    int unsigned nxt;
    int unsigned idx;
    longint best;
    longint cur;
    longint target;
    longint upd;
    pick_t p;
    nxt = int'(it.next_state) % NUM_STATES;
    if (it.kind == KIND_STEP) begin
      idx = (int'(it.prev_state) % NUM_STATES) * NUM_ACT + int'(it.prev_action);
      cur = q_table[idx];
      void'(greedy_action(nxt, best));
      target = longint'($signed(it.reward)) * (64'sd1 <<< Q_FRAC) + scale_q16(best, gamma_q16);
      upd = cur + scale_q16(target - cur, lr_q16);
      if (upd > Q_MAX) begin
        upd = Q_MAX;
        sat_updates++;
      end else if (upd < Q_MIN) begin
        upd = Q_MIN;
        sat_updates++;
      end
      q_table[idx] = upd;
    end
    if (it.draw > it.epsilon) begin
      p.action   = greedy_action(nxt, best);
      p.explored = 1'b0;
    end else begin
      p.action   = it.random_action;
      p.explored = 1'b1;
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  // Register write: setup cycle, then access cycle until pready is seen high.
  task automatic write_reg(input logic idx, input logic [RATE_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LEARN_RATE)
      lr_q16 = value;
    else
      gamma_q16 = value;
  endtask

  task automatic set_rates(input logic [RATE_W-1:0] lr, input logic [RATE_W-1:0] gamma);
    write_reg(REG_LEARN_RATE, lr);
    write_reg(REG_DISCOUNT, gamma);
    settings_done++;
  endtask

  // Offers one item in the sender's current burst and returns the predicted pick once
  // the block takes it. Between bursts the sender drops item_valid and idles.
  task automatic send_item(input agent_item_t it, input logic typed_in, input pick_t want,
                           output pick_t pick);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 16);
    end
    burst_left--;
    item_valid         <= 1'b1;
    kind               <= it.kind;
    prev_state         <= it.prev_state;
    prev_action        <= it.prev_action;
    reward             <= it.reward;
    next_state         <= it.next_state;
    epsilon_hundredths <= it.epsilon;
    random_draw        <= it.draw;
    random_action      <= it.random_action;
    do @(posedge clk); while (item_stall);
    // Taken at this edge: predict in acceptance order.
    pick = predict_pick(it);
    pending_picks.push_back(typed_in ? want : pick);
    items_sent++;
    if (it.kind == KIND_STEP)
      step_items++;
  endtask

  task automatic stop_sending();
    item_valid <= 1'b0;
    burst_left = 0;
  endtask

  // All results in, then a drain margin before the caller goes on.
  task automatic wait_idle();
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic agent_item_t random_fields();
    agent_item_t it;
    it.kind          = 1'($urandom_range(0, 1));
    it.prev_state    = STATE_W'($urandom);
    it.prev_action   = ACT_W'($urandom);
    it.reward        = REWARD_W'($urandom);
    it.next_state    = STATE_W'($urandom);
    it.epsilon       = PROB_W'($urandom_range(0, 127));
    it.draw          = PROB_W'($urandom_range(0, 127));
    it.random_action = ACT_W'($urandom);
    return it;
  endfunction

  // Mostly small rewards, now and then a terminal reward at either extreme.
  function automatic logic signed [REWARD_W-1:0] episode_reward();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return 17'sd65535;
    if (r == 1)
      return -17'sd65535;
    return REWARD_W'(int'($urandom_range(0, 40)) - 20);
  endfunction

  // An agent episode in a small cluster of states: a start item, then transitions that
  // carry the last picked action back as prev_action, as a real environment would.
  task automatic run_episode();
    agent_item_t it;
    pick_t pk;
    logic [STATE_W-1:0] base;
    logic [STATE_W-1:0] here;
    int span;
    int len;
    int eps;
    base = STATE_W'($urandom);
    span = $urandom_range(4, 16);
    len  = $urandom_range(5, 30);
    eps  = $urandom_range(0, 100);
    here = base + STATE_W'($urandom_range(0, span - 1));
    it = random_fields();
    it.kind       = KIND_START;
    it.next_state = here;
    it.epsilon    = PROB_W'(eps);
    it.draw       = PROB_W'($urandom_range(0, 99));
    send_item(it, 1'b0, '0, pk);
    repeat (len) begin
      it = random_fields();
      it.kind        = KIND_STEP;
      it.prev_state  = here;
      it.prev_action = pk.action;
      here = base + STATE_W'($urandom_range(0, span - 1));
      it.next_state  = here;
      it.reward      = episode_reward();
      it.epsilon     = PROB_W'(eps);
      it.draw        = PROB_W'($urandom_range(0, 99));
      send_item(it, 1'b0, '0, pk);
    end
  endtask

  // Same state over and over with an extreme reward, cycling through the actions, so
  // the values run into either end of the Q range.
  task automatic run_saturation();
    agent_item_t it;
    pick_t pk;
    logic [STATE_W-1:0] s;
    logic signed [REWARD_W-1:0] r;
    int len;
    s   = STATE_W'($urandom);
    r   = ($urandom_range(0, 1) != 0) ? 17'sd65535 : -17'sd65535;
    len = $urandom_range(20, 40);
    for (int i = 0; i < len; i++) begin
      it = random_fields();
      it.kind        = KIND_STEP;
      it.prev_state  = s;
      it.prev_action = ACT_W'(i);
      it.reward      = r;
      it.next_state  = s;
      it.epsilon     = PROB_W'(0);
      it.draw        = PROB_W'($urandom_range(1, 99));
      send_item(it, 1'b0, '0, pk);
    end
  endtask

  task automatic run_noise();
    pick_t pk;
    repeat ($urandom_range(5, 20)) send_item(random_fields(), 1'b0, '0, pk);
  endtask

  // Result checker: every taken result must match the oldest pending pick.
  always @(posedge clk) begin : result_check
    pick_t exp_pick;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_picks.size() == 0) begin
        report_mismatch("result with no item outstanding", 0, int'(chosen_action));
      end else begin
        exp_pick = pending_picks.pop_front();
        if (exp_pick.explored)
          explore_picks++;
        if (chosen_action !== exp_pick.action)
          report_mismatch("chosen_action", int'(exp_pick.action), int'(chosen_action));
        if (explored !== exp_pick.explored)
          report_mismatch("explored", int'(exp_pick.explored), int'(explored));
      end
    end
  end

  // Result-side back-pressure. It cycles through stretches with no stall, light and
  // heavy random stalls. When the stimulus asks for a hold, the stall is kept high
  // through a long hold while the sender keeps offering, so the output register and
  // the sequencer fill and item_stall has to rise.
  initial begin : result_backpressure
    int span;
    int pct;
    forever begin
      if (holds_done < holds_asked) begin
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          result_stall <= 1'b1;
        end
        holds_done++;
      end else begin
        span = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: pct = 0;
          1: pct = 30;
          default: pct = 75;
        endcase
        repeat (span) begin
          @(posedge clk);
          result_stall <= ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  // Main stimulus. Reset is applied once; the block then clears its table, holding
  // item_stall high, and the rates are written during that pass. The directed table
  // runs with both rates at their maximum so that saturation shows up quickly. Each
  // random phase then runs under its own pair of rates; the rates only change once
  // every pick is back and the block has had time to finish its last write-back.
  initial begin : stimulus
    logic [RATE_W-1:0] phase_lr [NUM_PHASES];
    logic [RATE_W-1:0] phase_gamma [NUM_PHASES];
    pick_t pk;
    int phase_end;
    int sel;
    phase_lr    = '{LEARN_RATE_RST, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0};
    phase_gamma = '{DISCOUNT_RST, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0};
    phase_lr[4]    = RATE_W'($urandom);
    phase_gamma[4] = RATE_W'($urandom);
    phase_lr[5]    = RATE_W'($urandom);
    phase_gamma[5] = RATE_W'($urandom);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    set_rates(16'hFFFF, 16'hFFFF);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed_in, directed_rows[i].want, pk);
    stop_sending();
    wait_idle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      set_rates(phase_lr[phase], phase_gamma[phase]);
      // Long receiver hold-off in two of the phases.
      if (phase == 0 || phase == 3)
        holds_asked++;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)
          run_episode();
        else if (sel < 85)
          run_saturation();
        else
          run_noise();
      end
      stop_sending();
      wait_idle();
    end

    $display("Covered %0d items (%0d transitions, %0d explore picks) under %0d rate settings,",
             items_sent, step_items, explore_picks, settings_done);
    $display("%0d updates clipped at the Q range, %0d results checked, %0d long result holds.",
             sat_updates, results_seen, holds_done);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d pick(s) outstanding after %0d items.",
             pending_picks.size(), items_sent);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
